FILE: hdl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg - shared types and constants of the segment projector
// Field structs, register map, datapath widths and small helpers.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int SCREEN_WIDTH   = 1024;
  localparam int SCREEN_HEIGHT  = 1024;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;

  // datapath widths
  localparam int REG_W   = 16;
  localparam int PT_W    = 14;                       // centred grid coordinate
  localparam int H_W     = 16;
  localparam int P1_W    = H_W + REG_W;              // first rotation products
  localparam int Y1_W    = P1_W + 1;
  localparam int QA_W    = PT_W + REG_W;
  localparam int QB_W    = Y1_W + REG_W;
  localparam int SUM2_W  = ((QA_W + TRIG_FRAC_BITS > QB_W) ?
                            QA_W + TRIG_FRAC_BITS : QB_W) + 1;
  localparam int X2_W    = SUM2_W - TRIG_FRAC_BITS;
  localparam int R_W     = X2_W + REG_W;
  localparam int S3_W    = ((R_W > Y1_W + REG_W) ? R_W : Y1_W + REG_W) + 1;
  localparam int XY_W    = 26;                       // holds +-2^24
  localparam int XY_LIMIT = 1 << 24;
  localparam int DIST_W  = REG_W + 1;
  localparam int DEN_W   = ((DIST_W + 1 + TRIG_FRAC_BITS > X2_W) ?
                            DIST_W + 1 + TRIG_FRAC_BITS : X2_W) + 1;
  localparam int HC_W    = 13;                       // signed half screen
  localparam int N_W     = XY_W + DIST_W;
  localparam int HD_W    = DEN_W + HC_W;
  localparam int NUM_W   = ((N_W + TRIG_FRAC_BITS > HD_W) ?
                            N_W + TRIG_FRAC_BITS : HD_W) + 1;
  localparam int DIV_DEN_W = DEN_W - 1;

  // pipeline shape
  localparam int QBITS       = 17;
  localparam int DIV_STAGES  = QBITS + 1;
  localparam int PRE_STAGES  = 9;
  localparam int LANE_STAGES = PRE_STAGES + DIV_STAGES + 1;
  localparam int NUM_STAGES  = LANE_STAGES + 1;

  localparam int CFG_IDX_W = 3;
  localparam logic signed [REG_W-1:0] TRIG_ONE = REG_W'(1 << TRIG_FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_X  = 3'd0,
    REG_SIN_X  = 3'd1,
    REG_COS_Y  = 3'd2,
    REG_SIN_Y  = 3'd3,
    REG_COS_Z  = 3'd4,
    REG_SIN_Z  = 3'd5,
    REG_DIST   = 3'd6,
    REG_OFFSET = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] cos_about_x;
    logic signed [15:0] sin_about_x;
    logic signed [15:0] cos_about_y;
    logic signed [15:0] sin_about_y;
    logic signed [15:0] cos_about_z;
    logic signed [15:0] sin_about_z;
    logic        [15:0] view_distance;
    logic signed [15:0] depth_offset;
  } cfg_t;

  typedef struct packed {
    logic        [11:0] start_x;
    logic        [11:0] start_y;
    logic signed [15:0] height_start;
    logic signed [15:0] height_end;
    logic        [9:0]  step_size;
    logic               along_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] screen_x_start;
    logic signed [15:0] screen_y_start;
    logic signed [15:0] screen_x_end;
    logic signed [15:0] screen_y_end;
    logic               behind_eye;
  } out_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               behind;
  } lane_res_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [QBITS-1:0] mag;
  } div_res_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

FILE: hdl/wsp_flow.sv
// ----------------------------------------------------------------------------
// wsp_flow - pipeline occupancy and stage enables
// One valid bit per stage; a stage loads when a slot at or after it is free or the output drains.
// ----------------------------------------------------------------------------
module wsp_flow (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wsp_pkg::NUM_STAGES-1:0]  en
);

  localparam int N = wsp_pkg::NUM_STAGES;

  logic [N-1:0] v;

  // stage k may load when a slot at or after k is empty, or the output drains
  always_comb begin
    for (int k = 0; k < N; k++) begin
      en[k] = out_ready || (((~v) >> k) != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[N-1];

  a_fill_rate: assert property (@(posedge clk) disable iff (rst)
    !rst |=> $countones(v) <= $past($countones(v)) + 1)
    else $error("occupancy grew by more than one");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted segment not in first stage");

  a_bubble: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !v[N-2]) |=> !out_valid)
    else $error("result appeared from an empty stage");

endmodule

FILE: hdl/wsp_div.sv
// ----------------------------------------------------------------------------
// wsp_div - pipelined restoring divider, one quotient bit per step stage
// Magnitude quotient of |num| / den with an overflow flag past QBITS bits.
// ----------------------------------------------------------------------------
module wsp_div (
  input  logic                                   clk,
  input  logic [wsp_pkg::DIV_STAGES-1:0]         en,
  input  logic signed [wsp_pkg::NUM_W-1:0]       num,
  input  logic [wsp_pkg::DIV_DEN_W-1:0]          den,
  output wsp_pkg::div_res_t                      res
);

  localparam int NW = wsp_pkg::NUM_W;
  localparam int QB = wsp_pkg::QBITS;

  logic [NW-1:0]                    rem [wsp_pkg::DIV_STAGES];
  logic [QB-1:0]                    quo [wsp_pkg::DIV_STAGES];
  logic                             neg [wsp_pkg::DIV_STAGES];
  logic                             ovf [wsp_pkg::DIV_STAGES];
  logic [wsp_pkg::DIV_DEN_W-1:0]    dd  [wsp_pkg::DIV_STAGES];

  // stage 0: magnitude and sign
  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg[0] <= num[NW-1];
      rem[0] <= num[NW-1] ? NW'(-num) : NW'(num);
      quo[0] <= '0;
      ovf[0] <= 1'b0;
      dd[0]  <= den;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int J = QB - k;
    logic [NW-1:0] trial;
    logic          take;
    logic          ovf_in;

    assign trial = NW'(dd[k-1]) << J;
    assign take  = rem[k-1] >= trial;

    if (k == 1) begin : g_first
      // quotient would not fit: saturate later
      assign ovf_in = rem[0] >= (NW'(dd[0]) << QB);
    end else begin : g_rest
      assign ovf_in = ovf[k-1];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= take ? rem[k-1] - trial : rem[k-1];
        quo[k] <= quo[k-1] | (take ? (QB'(1) << J) : '0);
        neg[k] <= neg[k-1];
        ovf[k] <= ovf_in;
        dd[k]  <= dd[k-1];
      end
    end
  end

  assign res.neg = neg[QB];
  assign res.ovf = ovf[QB];
  assign res.mag = quo[QB];

endmodule

FILE: hdl/wsp_lane.sv
// ----------------------------------------------------------------------------
// wsp_lane - projection pipeline for one endpoint
// Three rotations, truncation, perspective numerator and divide, saturation.
// ----------------------------------------------------------------------------
module wsp_lane (
  input  logic                                clk,
  input  logic [wsp_pkg::LANE_STAGES-1:0]     en,
  input  wsp_pkg::cfg_t                       cfg,
  input  logic signed [wsp_pkg::PT_W-1:0]     pt_x,
  input  logic signed [wsp_pkg::PT_W-1:0]     pt_y,
  input  logic signed [wsp_pkg::H_W-1:0]      h,
  output wsp_pkg::lane_res_t                  res
);

  localparam int F  = wsp_pkg::TRIG_FRAC_BITS;
  localparam int PS = wsp_pkg::PRE_STAGES;
  localparam int DS = wsp_pkg::DIV_STAGES;
  localparam logic signed [wsp_pkg::S3_W-1:0] TRUNC_BIAS =
    (wsp_pkg::S3_W'(1) << (2 * F)) - wsp_pkg::S3_W'(1);
  localparam logic signed [wsp_pkg::S3_W-1:0] NO_BIAS = wsp_pkg::S3_W'(0);
  localparam logic signed [wsp_pkg::S3_W-1:0] XY_LIM =
    wsp_pkg::S3_W'(wsp_pkg::XY_LIMIT);
  localparam logic signed [wsp_pkg::HC_W-1:0] HX = wsp_pkg::HC_W'(wsp_pkg::HALF_W);
  localparam logic signed [wsp_pkg::HC_W-1:0] HY = wsp_pkg::HC_W'(wsp_pkg::HALF_H);

  typedef struct packed {
    logic signed [15:0] ortho_x;
    logic signed [15:0] ortho_y;
    logic               behind;
  } side_t;

  logic signed [15:0] cxc, sxs, cyc, sys, czc, szs, off;
  logic signed [wsp_pkg::DIST_W-1:0] dist_s;
  logic persp;

  assign cxc    = cfg.cos_about_x;
  assign sxs    = cfg.sin_about_x;
  assign cyc    = cfg.cos_about_y;
  assign sys    = cfg.sin_about_y;
  assign czc    = cfg.cos_about_z;
  assign szs    = cfg.sin_about_z;
  assign off    = cfg.depth_offset;
  assign dist_s = {1'b0, cfg.view_distance};
  assign persp  = cfg.view_distance != '0;

  // S1/S2: rotate about x
  logic signed [wsp_pkg::P1_W-1:0] p_a, p_b, p_c, p_d;
  logic signed [wsp_pkg::PT_W-1:0] cx1, cx2;
  logic signed [wsp_pkg::Y1_W-1:0] y1, z1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_a <= wsp_pkg::P1_W'(pt_y) * wsp_pkg::P1_W'(cxc);
      p_b <= wsp_pkg::P1_W'(h) * wsp_pkg::P1_W'(sxs);
      p_c <= wsp_pkg::P1_W'(h) * wsp_pkg::P1_W'(cxc);
      p_d <= wsp_pkg::P1_W'(pt_y) * wsp_pkg::P1_W'(sxs);
      cx1 <= pt_x;
    end
    if (en[1]) begin
      y1  <= wsp_pkg::Y1_W'(p_a) + wsp_pkg::Y1_W'(p_b);
      z1  <= wsp_pkg::Y1_W'(p_c) - wsp_pkg::Y1_W'(p_d);
      cx2 <= cx1;
    end
  end

  // S3/S4: rotate about y, floor back to Q.F
  logic signed [wsp_pkg::QA_W-1:0]   q_a, q_d;
  logic signed [wsp_pkg::QB_W-1:0]   q_b, q_c;
  logic signed [wsp_pkg::Y1_W-1:0]   y1_3, y1_4;
  logic signed [wsp_pkg::SUM2_W-1:0] sum_x2, sum_z2;
  logic signed [wsp_pkg::X2_W-1:0]   x2, z2;

  assign sum_x2 = (wsp_pkg::SUM2_W'(q_a) <<< F) + wsp_pkg::SUM2_W'(q_b);
  assign sum_z2 = wsp_pkg::SUM2_W'(q_c) - (wsp_pkg::SUM2_W'(q_d) <<< F);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_a  <= wsp_pkg::QA_W'(cx2) * wsp_pkg::QA_W'(cyc);
      q_b  <= wsp_pkg::QB_W'(z1) * wsp_pkg::QB_W'(sys);
      q_c  <= wsp_pkg::QB_W'(z1) * wsp_pkg::QB_W'(cyc);
      q_d  <= wsp_pkg::QA_W'(cx2) * wsp_pkg::QA_W'(sys);
      y1_3 <= y1;
    end
    if (en[3]) begin
      x2   <= wsp_pkg::X2_W'(sum_x2 >>> F);
      z2   <= wsp_pkg::X2_W'(sum_z2 >>> F);
      y1_4 <= y1_3;
    end
  end

  // S5/S6: rotate about z; denominator d*2^F - (z + off*2^F)
  // z stays far inside the +-2^46 clamp, so the clamp is left out.
  logic signed [wsp_pkg::R_W-1:0]  r_a, r_b, r_c, r_d;
  logic signed [wsp_pkg::X2_W-1:0] z2_5;
  logic signed [wsp_pkg::S3_W-1:0] s_x, s_y;
  logic signed [wsp_pkg::DEN_W-1:0] den6;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r_a  <= wsp_pkg::R_W'(x2) * wsp_pkg::R_W'(czc);
      r_b  <= wsp_pkg::R_W'(y1_4) * wsp_pkg::R_W'(szs);
      r_c  <= wsp_pkg::R_W'(y1_4) * wsp_pkg::R_W'(czc);
      r_d  <= wsp_pkg::R_W'(x2) * wsp_pkg::R_W'(szs);
      z2_5 <= z2;
    end
    if (en[5]) begin
      s_x  <= wsp_pkg::S3_W'(r_a) - wsp_pkg::S3_W'(r_b);
      s_y  <= wsp_pkg::S3_W'(r_c) + wsp_pkg::S3_W'(r_d);
      den6 <= ((wsp_pkg::DEN_W'(dist_s) - wsp_pkg::DEN_W'(off)) <<< F)
              - wsp_pkg::DEN_W'(z2_5);
    end
  end

  // S7: truncate toward zero, clamp to +-2^24
  logic signed [wsp_pkg::S3_W-1:0] t_x, t_y, c_x, c_y;
  logic signed [wsp_pkg::XY_W-1:0] x7, y7;
  logic signed [wsp_pkg::DEN_W-1:0] den7;
  logic behind7;

  always_comb begin
    t_x = (s_x + (s_x[wsp_pkg::S3_W-1] ? TRUNC_BIAS : NO_BIAS)) >>> (2 * F);
    t_y = (s_y + (s_y[wsp_pkg::S3_W-1] ? TRUNC_BIAS : NO_BIAS)) >>> (2 * F);
    if (t_x > XY_LIM) c_x = XY_LIM;
    else if (t_x < -XY_LIM) c_x = -XY_LIM;
    else c_x = t_x;
    if (t_y > XY_LIM) c_y = XY_LIM;
    else if (t_y < -XY_LIM) c_y = -XY_LIM;
    else c_y = t_y;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      x7      <= wsp_pkg::XY_W'(c_x);
      y7      <= wsp_pkg::XY_W'(c_y);
      den7    <= den6;
      behind7 <= persp && !(den6 > 0);
    end
  end

  // S8/S9: numerator X*d*2^F + centre*den
  logic signed [wsp_pkg::N_W-1:0]   n_x, n_y;
  logic signed [wsp_pkg::HD_W-1:0]  hd_x, hd_y;
  logic signed [wsp_pkg::DEN_W-1:0] den8, den9;
  logic signed [wsp_pkg::NUM_W-1:0] num_x, num_y;
  side_t side8, side9;
  side_t side_d [DS];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      n_x  <= wsp_pkg::N_W'(x7) * wsp_pkg::N_W'(dist_s);
      n_y  <= wsp_pkg::N_W'(y7) * wsp_pkg::N_W'(dist_s);
      hd_x <= wsp_pkg::HD_W'(den7) * wsp_pkg::HD_W'(HX);
      hd_y <= wsp_pkg::HD_W'(den7) * wsp_pkg::HD_W'(HY);
      den8 <= den7;
      side8.ortho_x <= wsp_pkg::sat16(32'(x7) + 32'(HX));
      side8.ortho_y <= wsp_pkg::sat16(32'(y7) + 32'(HY));
      side8.behind  <= behind7;
    end
    if (en[8]) begin
      num_x <= (wsp_pkg::NUM_W'(n_x) <<< F) + wsp_pkg::NUM_W'(hd_x);
      num_y <= (wsp_pkg::NUM_W'(n_y) <<< F) + wsp_pkg::NUM_W'(hd_y);
      den9  <= den8;
      side9 <= side8;
    end
  end

  // divide stages; side data rides alongside
  wsp_pkg::div_res_t dq_x, dq_y;

  wsp_div u_div_x (
    .clk (clk),
    .en  (en[PS +: DS]),
    .num (num_x),
    .den (den9[wsp_pkg::DIV_DEN_W-1:0]),
    .res (dq_x)
  );

  wsp_div u_div_y (
    .clk (clk),
    .en  (en[PS +: DS]),
    .num (num_y),
    .den (den9[wsp_pkg::DIV_DEN_W-1:0]),
    .res (dq_y)
  );

  always_ff @(posedge clk) begin
    if (en[PS]) side_d[0] <= side9;
    for (int k = 1; k < DS; k++) begin
      if (en[PS + k]) side_d[k] <= side_d[k-1];
    end
  end

  // final: sign, saturation, mode select
  function automatic logic signed [15:0] finish(input wsp_pkg::div_res_t d);
    logic signed [31:0] m;
    logic signed [15:0] r;
    m = 32'(signed'({1'b0, d.mag}));
    if (d.ovf) r = d.neg ? 16'sh8000 : 16'sh7fff;
    else r = wsp_pkg::sat16(d.neg ? -m : m);
    return r;
  endfunction

  side_t side_f;
  assign side_f = side_d[DS-1];

  always_ff @(posedge clk) begin
    if (en[PS + DS]) begin
      res.behind <= side_f.behind;
      if (side_f.behind) begin
        res.sx <= '0;
        res.sy <= '0;
      end else if (persp) begin
        res.sx <= finish(dq_x);
        res.sy <= finish(dq_y);
      end else begin
        res.sx <= side_f.ortho_x;
        res.sy <= side_f.ortho_y;
      end
    end
  end

endmodule

FILE: hdl/wsp_merge.sv
// ----------------------------------------------------------------------------
// wsp_merge - output register joining the two endpoint lanes
// Packs both endpoints and ORs their behind-the-eye flags.
// ----------------------------------------------------------------------------
module wsp_merge (
  input  logic                clk,
  input  logic                en,
  input  wsp_pkg::lane_res_t  lane_start,
  input  wsp_pkg::lane_res_t  lane_end,
  output wsp_pkg::out_t       out
);

  always_ff @(posedge clk) begin
    if (en) begin
      out.screen_x_start <= lane_start.sx;
      out.screen_y_start <= lane_start.sy;
      out.screen_x_end   <= lane_end.sx;
      out.screen_y_end   <= lane_end.sy;
      out.behind_eye     <= lane_start.behind | lane_end.behind;
    end
  end

endmodule

FILE: hdl/wireframe_segment_projector_unit.sv
// ----------------------------------------------------------------------------
// wireframe_segment_projector_unit - rotate and project wireframe segments
// Two endpoint lanes, a shared flow controller and an output merge register.
// ----------------------------------------------------------------------------
// One segment transfer per clock is sustained while the output takes results;
// each segment's perspective path goes through the 17-step pipelined divider,
// one quotient bit per step stage after a magnitude stage in front. Both
// endpoints run side by side in identical lanes: rotation about x, y, z in
// Q1.14 with a registered multiply ahead of each add, truncation to integers,
// then either the orthographic offset or d/(d - (z + offset)) scaling, and a
// final 16-bit saturation. The merge register ORs the two behind-the-eye flags.
// Holes in the pipeline close up while the output stalls, so new segments are
// still taken until every stage is full. The config port is always ready;
// registers may only be written while no segment is in flight.
module wireframe_segment_projector_unit (
  input  logic                             clk,
  input  logic                             rst,
  // segment input
  input  logic                             seg_valid,
  output logic                             seg_ready,
  input  wsp_pkg::in_t                     seg,
  // projected output
  output logic                             proj_valid,
  input  logic                             proj_ready,
  output wsp_pkg::out_t                    proj,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);

  localparam int PW = wsp_pkg::PT_W;

  wsp_pkg::cfg_t cfg;

  // register file; written by transfer on the config channel
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_about_x   <= wsp_pkg::TRIG_ONE;
      cfg.sin_about_x   <= '0;
      cfg.cos_about_y   <= wsp_pkg::TRIG_ONE;
      cfg.sin_about_y   <= '0;
      cfg.cos_about_z   <= wsp_pkg::TRIG_ONE;
      cfg.sin_about_z   <= '0;
      cfg.view_distance <= '0;
      cfg.depth_offset  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (wsp_pkg::cfg_idx_t'(cfg_index))
        wsp_pkg::REG_COS_X:  cfg.cos_about_x   <= cfg_data;
        wsp_pkg::REG_SIN_X:  cfg.sin_about_x   <= cfg_data;
        wsp_pkg::REG_COS_Y:  cfg.cos_about_y   <= cfg_data;
        wsp_pkg::REG_SIN_Y:  cfg.sin_about_y   <= cfg_data;
        wsp_pkg::REG_COS_Z:  cfg.cos_about_z   <= cfg_data;
        wsp_pkg::REG_SIN_Z:  cfg.sin_about_z   <= cfg_data;
        wsp_pkg::REG_DIST:   cfg.view_distance <= cfg_data;
        wsp_pkg::REG_OFFSET: cfg.depth_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  // centre both endpoints; the end point steps along x or y
  logic signed [PW-1:0] st_x, st_y, step_s, end_x, end_y;

  assign st_x   = PW'(signed'({1'b0, seg.start_x})) - PW'(wsp_pkg::HALF_W);
  assign st_y   = PW'(signed'({1'b0, seg.start_y})) - PW'(wsp_pkg::HALF_H);
  assign step_s = PW'(signed'({1'b0, seg.step_size}));
  assign end_x  = seg.along_y ? st_x : st_x + step_s;
  assign end_y  = seg.along_y ? st_y + step_s : st_y;

  // stage enables shared by both lanes and the merge register
  logic [wsp_pkg::NUM_STAGES-1:0] en;

  wsp_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .out_valid (proj_valid),
    .out_ready (proj_ready),
    .en        (en)
  );

  wsp_pkg::lane_res_t res_start, res_end;

  wsp_lane u_lane_start (
    .clk  (clk),
    .en   (en[wsp_pkg::LANE_STAGES-1:0]),
    .cfg  (cfg),
    .pt_x (st_x),
    .pt_y (st_y),
    .h    (seg.height_start),
    .res  (res_start)
  );

  wsp_lane u_lane_end (
    .clk  (clk),
    .en   (en[wsp_pkg::LANE_STAGES-1:0]),
    .cfg  (cfg),
    .pt_x (end_x),
    .pt_y (end_y),
    .h    (seg.height_end),
    .res  (res_end)
  );

  wsp_merge u_merge (
    .clk        (clk),
    .en         (en[wsp_pkg::NUM_STAGES-1]),
    .lane_start (res_start),
    .lane_end   (res_end),
    .out        (proj)
  );

endmodule

FILE: tb/wireframe_segment_projector_unit_tb.sv
// ----------------------------------------------------------------------------
// wireframe_segment_projector_unit_tb - self-checking bench for the projector
// Drives segments and register writes over valid/ready, predicts every
// projected segment in a scoreboard class and checks the results in order.
// ----------------------------------------------------------------------------
module wireframe_segment_projector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsp_pkg::*;

  // Expected projections plus our own copy of the register file.
  class proj_scoreboard;
    cfg_t   regs;
    out_t   pending[$];
    int     errors;
    int     checked;
    int     behind_seen;

    function new();
      regs = '0;
      regs.cos_about_x = 16'sd16384;
      regs.cos_about_y = 16'sd16384;
      regs.cos_about_z = 16'sd16384;
      errors = 0;
      checked = 0;
      behind_seen = 0;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint clampv(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint tshift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v) >>> s);
    endfunction

    // One endpoint through rotate x, y, z and the projection.
    function bit project_point(longint cx, longint cy, longint h,
                               output logic signed [15:0] ox,
                               output logic signed [15:0] oy);
      longint one, cxc, sxs, cyc, sys, czc, szs, eye_d, off;
      longint y1, z1, x2, z2, rx, ry, den;
      one   = 64'sd1 <<< TRIG_FRAC_BITS;
      cxc   = longint'(regs.cos_about_x);
      sxs   = longint'(regs.sin_about_x);
      cyc   = longint'(regs.cos_about_y);
      sys   = longint'(regs.sin_about_y);
      czc   = longint'(regs.cos_about_z);
      szs   = longint'(regs.sin_about_z);
      eye_d = longint'(regs.view_distance);
      off   = longint'(regs.depth_offset);
      y1 = cy * cxc + h * sxs;
      z1 = h * cxc - cy * sxs;
      x2 = (cx * one * cyc + z1 * sys) >>> TRIG_FRAC_BITS;   // floor
      z2 = (z1 * cyc - cx * one * sys) >>> TRIG_FRAC_BITS;
      rx = clampv(tshift(x2 * czc - y1 * szs, 2 * TRIG_FRAC_BITS), 64'sd1 <<< 24);
      ry = clampv(tshift(y1 * czc + x2 * szs, 2 * TRIG_FRAC_BITS), 64'sd1 <<< 24);
      if (eye_d == 0) begin
        ox = clip16(rx + HALF_W);
        oy = clip16(ry + HALF_H);
        return 1'b0;
      end
      z2  = clampv(z2, 64'sd1 <<< 46);
      den = eye_d * one - (z2 + off * one);
      if (den <= 0) begin
        ox = '0;
        oy = '0;
        return 1'b1;
      end
      ox = clip16((rx * eye_d * one + HALF_W * den) / den);
      oy = clip16((ry * eye_d * one + HALF_H * den) / den);
      return 1'b0;
    endfunction

    function void note_segment(in_t s);
      out_t   e;
      longint cx, cy, ex, ey;
      bit     b0, b1;
      cx = longint'(s.start_x) - HALF_W;
      cy = longint'(s.start_y) - HALF_H;
      ex = s.along_y ? cx : cx + longint'(s.step_size);
      ey = s.along_y ? cy + longint'(s.step_size) : cy;
      b0 = project_point(cx, cy, longint'(s.height_start),
                         e.screen_x_start, e.screen_y_start);
      b1 = project_point(ex, ey, longint'(s.height_end),
                         e.screen_x_end, e.screen_y_end);
      e.behind_eye = b0 | b1;
      pending.push_back(e);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
    endtask

    task check_result(out_t r);
      out_t e;
      if (pending.size() == 0) begin
        report("unexpected result", r.screen_x_start, 16'h0000);
        return;
      end
      e = pending.pop_front();
      if (r.screen_x_start !== e.screen_x_start)
        report("screen_x_start", r.screen_x_start, e.screen_x_start);
      if (r.screen_y_start !== e.screen_y_start)
        report("screen_y_start", r.screen_y_start, e.screen_y_start);
      if (r.screen_x_end !== e.screen_x_end)
        report("screen_x_end", r.screen_x_end, e.screen_x_end);
      if (r.screen_y_end !== e.screen_y_end)
        report("screen_y_end", r.screen_y_end, e.screen_y_end);
      if (r.behind_eye !== e.behind_eye)
        report("behind_eye", 16'(r.behind_eye), 16'(e.behind_eye));
      if (e.behind_eye) behind_seen++;
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0, seg_ready;
  in_t  seg = '0;
  logic proj_valid, proj_ready = 1'b0;
  out_t proj;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  proj_scoreboard sb = new();
  bit     no_gaps = 1'b0;     // long stretch with both sides always active
  longint cycles = 0;
  int     sent = 0;
  int     phases = 0;

  wireframe_segment_projector_unit dut (
    .clk, .rst,
    .seg_valid, .seg_ready, .seg,
    .proj_valid, .proj_ready, .proj,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("wireframe_segment_projector_unit test failed");
      $finish;
    end
  end

  // Output side: check each accepted transfer, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      proj_ready <= 1'b0;
    end else begin
      if (proj_valid && proj_ready) sb.check_result(proj);
      proj_ready <= no_gaps || ($urandom_range(99) >= 37);
    end
  end

  // One segment transfer; random idle cycles ahead of it.
  task send_segment(in_t s);
    if (!no_gaps && $urandom_range(99) < 37) begin
      seg_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    seg       <= s;
    seg_valid <= 1'b1;
    do @(posedge clk); while (!seg_ready);
    sb.note_segment(s);
    sent++;
  endtask

  // Valid stays up across back-to-back writes; the caller drops it.
  task write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers change only with the pipeline empty.
  task load_config(cfg_t c);
    seg_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(REG_COS_X,  c.cos_about_x);
    write_reg(REG_SIN_X,  c.sin_about_x);
    write_reg(REG_COS_Y,  c.cos_about_y);
    write_reg(REG_SIN_Y,  c.sin_about_y);
    write_reg(REG_COS_Z,  c.cos_about_z);
    write_reg(REG_SIN_Z,  c.sin_about_z);
    write_reg(REG_DIST,   c.view_distance);
    write_reg(REG_OFFSET, c.depth_offset);
    cfg_valid <= 1'b0;
    sb.regs = c;
    phases++;
  endtask

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic in_t rand_segment(bit persp);
    in_t s;
    s = in_t'({$urandom, $urandom, $urandom});
    // Small heights keep most perspective points in front of the eye.
    if (persp && $urandom_range(3) != 0) begin
      s.height_start = 16'($signed($urandom_range(2000)) - 1000);
      s.height_end   = 16'($signed($urandom_range(2000)) - 1000);
    end
    if ($urandom_range(3) == 0) begin
      s.start_x = 12'($urandom_range(1024));
      s.start_y = 12'($urandom_range(1024));
    end
    return s;
  endfunction

  function automatic in_t mk(int x, int y, int h0, int h1, int st, bit ay);
    in_t s;
    s.start_x = 12'(x);
    s.start_y = 12'(y);
    s.height_start = 16'(h0);
    s.height_end   = 16'(h1);
    s.step_size = 10'(st);
    s.along_y = ay;
    return s;
  endfunction

  initial begin
    cfg_t c;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, orthographic at reset values: field extremes, both directions.
    send_segment(mk(0, 0, -32768, 32767, 0, 0));
    send_segment(mk(4095, 4095, 32767, -32768, 1023, 1));
    send_segment(mk(512, 512, 0, 0, 1023, 0));
    send_segment(mk(4095, 0, 12345, -1, 1, 1));

    // Extreme trig values, orthographic.
    c = '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384,
          -16'sd16384, 16'sd16384, 16'd0, 16'sd0};
    load_config(c);
    send_segment(mk(4095, 4095, 32767, 32767, 1023, 0));
    send_segment(mk(0, 0, -32768, -32768, 1023, 1));

    // Perspective, identity rotation: den = (d - h - off) * 2^14.
    c = '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
          16'sd16384, 16'sd0, 16'd100, 16'sd20};
    load_config(c);
    send_segment(mk(600, 400, 80, 0, 10, 0));      // start exactly at the eye
    send_segment(mk(600, 400, 0, 90, 10, 1));      // end behind the eye
    send_segment(mk(600, 400, 79, 79, 10, 0));     // both just in front
    send_segment(mk(4095, 0, -32768, -32768, 1023, 1)); // far away
    send_segment(mk(0, 4095, 0, 0, 0, 0));

    // Largest distance, most negative offset; then smallest positive distance.
    c.view_distance = 16'hffff;
    c.depth_offset  = -16'sd32768;
    load_config(c);
    send_segment(mk(4095, 4095, 32767, -32768, 1023, 1));
    send_segment(mk(0, 0, 0, 0, 1023, 0));
    c.view_distance = 16'd1;
    c.depth_offset  = 16'sd32767;
    load_config(c);
    send_segment(mk(512, 512, -32768, -32768, 5, 0));
    send_segment(mk(10, 20, 0, 0, 5, 1));

    // Random phases, each with its own register settings.
    for (int p = 0; p < 9; p++) begin
      c.cos_about_x = rand_trig();
      c.sin_about_x = rand_trig();
      c.cos_about_y = rand_trig();
      c.sin_about_y = rand_trig();
      c.cos_about_z = rand_trig();
      c.sin_about_z = rand_trig();
      case (p % 3)
        0: c.view_distance = 16'd0;
        1: c.view_distance = 16'($urandom_range(65535));
        default: c.view_distance = 16'($urandom_range(3000));
      endcase
      c.depth_offset = ($urandom_range(1)) ? 16'($urandom) :
                       16'($signed($urandom_range(400)) - 200);
      load_config(c);
      no_gaps = (p == 4);
      for (int i = 0; i < 120; i++)
        send_segment(rand_segment(c.view_distance != 0));
      no_gaps = 1'b0;
    end

    seg_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("segments sent %0d, results checked %0d, behind the eye %0d",
             sent, sb.checked, sb.behind_seen);
    $display("register settings loaded %0d, mismatches %0d", phases, sb.errors);
    if (sb.errors == 0)
      $display("wireframe_segment_projector_unit test passed");
    else
      $display("wireframe_segment_projector_unit test failed");
    $finish;
  end

endmodule
